// ===== rtl/core/amqp_frame_deframer_core_defines.svh =====
// assertion macros for the deframer rtl
`ifndef AMQP_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define AMQP_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AFD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication, checked out of reset
`define AFD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

// ===== rtl/core/afd_pkg.sv =====
// types and constants for the amqp frame deframer
`default_nettype none

package afd_pkg;

  localparam int unsigned HdrLen        = 7;
  localparam int unsigned FrameOverhead = 8;
  localparam int unsigned MethodDataAt  = 11;
  localparam int unsigned PropsDataAt   = 19;
  localparam int unsigned MethodIdBytes = MethodDataAt - HdrLen;
  localparam int unsigned PropsSkipEnd  = PropsDataAt - HdrLen;
  localparam int unsigned ClassIdBytes  = 2;

  localparam logic [7:0] FrameEndByte = 8'hCE;
  localparam logic [7:0] KindMethod   = 8'd1;
  localparam logic [7:0] KindHeader   = 8'd2;
  localparam logic [7:0] KindBody     = 8'd3;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_BODY = 2'd1,
    PH_SKIP = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_DONE     = 3'd1,
    ST_BAD_END  = 3'd2,
    ST_OVERSIZE = 3'd3,
    ST_SHORT    = 3'd4
  } status_e;

  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [7:0]  frame_kind;
    logic [15:0] channel_number;
    logic [31:0] payload_size;
    logic [31:0] type_id;
    logic [7:0]  data_byte;
    logic [31:0] payload_index;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/amqp_frame_deframer_core.sv =====
// amqp frame deframer top level: byte register, parser, result register
// a byte accepted into the byte register is decoded by the parser, and its result is registered in the result register
// throughput: one byte per cycle, held back only while a result waits on a stalled output
// the parser decodes each byte combinationally with counters and compares
// reset: parser back to header collection, all captured fields cleared, max_frame_size 65536
`default_nettype none

`include "amqp_frame_deframer_core_defines.svh"

module amqp_frame_deframer_core import afd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       frame_kind_o,
  output logic [15:0]      channel_number_o,
  output logic [31:0]      payload_size_o,
  output logic [31:0]      type_id_o,
  output logic [7:0]       data_byte_o,
  output logic [31:0]      payload_index_o
);

  logic        s_valid_q;
  logic [7:0]  s_byte_q;
  logic [31:0] max_size_q;
  logic        out_valid_q;
  res_t        res_q;
  res_t        step_res;
  logic        adv;

  assign cfg_ready_o = 1'b1;

  // a byte moves on when it gives no result or the result slot is free
  assign adv        = s_valid_q && (!step_res.emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = s_valid_q && !adv;

  afd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .rx_byte_i       (s_byte_q),
    .max_frame_size_i(max_size_q),
    .res_o           (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= 32'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_size_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && step_res.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && step_res.emit) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign frame_kind_o     = res_q.frame_kind;
  assign channel_number_o = res_q.channel_number;
  assign payload_size_o   = res_q.payload_size;
  assign type_id_o        = res_q.type_id;
  assign data_byte_o      = res_q.data_byte;
  assign payload_index_o  = res_q.payload_index;

  `AFD_ASSERT_IMP(a_stall_needs_beat, in_stall_o, s_valid_q)
  `AFD_ASSERT_NXT(a_held_beat_stable, s_valid_q && in_stall_o, s_valid_q && $stable(s_byte_q))
  `AFD_ASSERT_IMP(a_props_skipped,
    out_valid_o && status_o == ST_DATA && frame_kind_o == KindHeader,
    payload_index_o >= 32'(PropsSkipEnd))
  `AFD_ASSERT_IMP(a_reject_fields_clear,
    out_valid_o && (status_o == ST_OVERSIZE || status_o == ST_SHORT),
    type_id_o == 32'd0 && data_byte_o == 8'd0 && payload_index_o == 32'd0)

endmodule

`default_nettype wire

// ===== rtl/core/afd_parser.sv =====
// frame parser state and per-byte decode
`default_nettype none

module afd_parser import afd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic [31:0] max_frame_size_i,
  output res_t             res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [7:0]  kind_q, kind_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] size_q, size_d;
  logic [31:0] id_q, id_d;

  logic        at_end;
  logic        hdr_last;
  logic [31:0] size_shift;
  logic        oversize;
  logic        too_short;

  assign at_end     = (cnt_q == size_q);
  assign hdr_last   = (cnt_q == 32'(HdrLen - 1));
  // size_shift is the completed size on the last header byte
  assign size_shift = {size_q[23:0], rx_byte_i};
  assign oversize = ({1'b0, size_shift} + 33'(FrameOverhead)) > {1'b0, max_frame_size_i};
  assign too_short = ((kind_q == KindMethod) && (size_shift < 32'(MethodIdBytes))) ||
                     ((kind_q == KindHeader) && (size_shift < 32'(PropsSkipEnd)));

  // next phase and byte count
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (phase_q)
      PH_BODY, PH_SKIP: begin
        if (at_end) begin
          phase_d = PH_HDR;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 32'd1;
        end
      end
      default: begin
        if (hdr_last) begin
          cnt_d   = '0;
          phase_d = (oversize || too_short) ? PH_SKIP : PH_BODY;
        end else begin
          phase_d = PH_HDR;
          cnt_d   = cnt_q + 32'd1;
        end
      end
    endcase
  end

  // captured fields and result
  always_comb begin
    kind_d = kind_q;
    chan_d = chan_q;
    size_d = size_q;
    id_d   = id_q;
    res_o  = '0;
    unique case (phase_q)
      PH_BODY: begin
        if (at_end) begin
          res_o.type_id = id_q;
          if (rx_byte_i != FrameEndByte) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_BAD_END;
          end else if (kind_q == KindMethod || kind_q == KindHeader ||
                       kind_q == KindBody) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_DONE;
          end
        end else begin
          res_o.data_byte     = rx_byte_i;
          res_o.payload_index = cnt_q;
          res_o.status        = ST_DATA;
          if (kind_q == KindMethod) begin
            if (cnt_q < 32'(MethodIdBytes)) begin
              id_d = {id_q[23:0], rx_byte_i};
            end else begin
              res_o.emit    = 1'b1;
              res_o.type_id = id_q;
            end
          end else if (kind_q == KindHeader) begin
            if (cnt_q < 32'(ClassIdBytes)) begin
              id_d = {16'h0000, id_q[7:0], rx_byte_i};
            end else if (cnt_q >= 32'(PropsSkipEnd)) begin
              res_o.emit    = 1'b1;
              res_o.type_id = id_q;
            end
          end else if (kind_q == KindBody) begin
            res_o.emit = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        res_o.emit = 1'b0;
      end
      default: begin
        case (cnt_q)
          32'd0: begin
            kind_d = rx_byte_i;
            chan_d = '0;
            size_d = '0;
            id_d   = '0;
          end
          32'd1:   chan_d = {rx_byte_i, 8'h00};
          32'd2:   chan_d = chan_q | {8'h00, rx_byte_i};
          default: size_d = size_shift;
        endcase
        if (hdr_last) begin
          id_d = '0;
          if (oversize) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_OVERSIZE;
          end else if (too_short) begin
            res_o.emit   = 1'b1;
            res_o.status = ST_SHORT;
          end
        end
      end
    endcase
    res_o.frame_kind     = kind_d;
    res_o.channel_number = chan_d;
    res_o.payload_size   = size_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      cnt_q   <= '0;
      kind_q  <= '0;
      chan_q  <= '0;
      size_q  <= '0;
      id_q    <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      kind_q  <= kind_d;
      chan_q  <= chan_d;
      size_q  <= size_d;
      id_q    <= id_d;
    end
  end

endmodule

`default_nettype wire
